// File: sv/ceq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceq_pkg
// Shared types and codes for the coalescing event queue.
// ----------------------------------------------------------------------------
package ceq_pkg;

    localparam int SUBJ_W = 4;
    localparam int ATYPE_W = 2;
    localparam int ADDR_W = 48;
    localparam int IDX_W = 8;
    localparam int ACT_W = 2;
    localparam int CMD_W = 2;
    localparam int STAT_W = 2;
    localparam int MASK_W = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [ACT_W-1:0] ACT_CREATE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_OTHER = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_MASK = 1'd1;

    // Match key of one event
    typedef struct packed {
        logic [SUBJ_W-1:0]  subject;
        logic [ATYPE_W-1:0] address_type;
        logic [ADDR_W-1:0]  device_address;
        logic [IDX_W-1:0]   item_index;
    } key_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic shift;    // every cell takes its younger neighbor
        logic drop;     // head entry leaves the chain during this shift
        logic hit_wr;   // head entry re-enters overwritten by the request
        logic append;   // request is written behind the youngest entry
    } cell_ctl_t;

endpackage

// File: sv/ceq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceq_if
// Valid/ready channel carrying one payload struct.
// ----------------------------------------------------------------------------
interface ceq_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/ceq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceq_cell
// One queue slot: holds an event and takes the value offered by the chain.
// ----------------------------------------------------------------------------
module ceq_cell #(
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                        clk,
    input  logic                        wr,
    input  ceq_pkg::key_t               in_key,
    input  logic [ceq_pkg::ACT_W-1:0]   in_act,
    input  logic [PAYLOAD_BITS-1:0]     in_pay,
    output ceq_pkg::key_t               key,
    output logic [ceq_pkg::ACT_W-1:0]   act,
    output logic [PAYLOAD_BITS-1:0]     pay
);
    import ceq_pkg::*;

    key_t                key_reg;
    logic [ACT_W-1:0]    act_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            key_reg <= in_key;
            act_reg <= in_act;
            pay_reg <= in_pay;
        end
    end

    assign key = key_reg;
    assign act = act_reg;
    assign pay = pay_reg;
endmodule

// File: sv/ceq_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceq_match
// Event match compare between a stored key and the search key.
// ----------------------------------------------------------------------------
module ceq_match (
    input  ceq_pkg::key_t               a,
    input  ceq_pkg::key_t               b,
    input  logic [ceq_pkg::MASK_W-1:0]  addr_mask,
    input  logic [ceq_pkg::MASK_W-1:0]  idx_mask,
    output logic                        hit
);
    import ceq_pkg::*;

    always_comb
    begin
        if (a.subject != b.subject)
            hit = 1'b0;
        else if (addr_mask[a.subject])
            hit = (a.address_type == b.address_type) &&
                  (a.device_address == b.device_address);
        else if (idx_mask[a.subject])
            hit = (a.item_index == b.item_index);
        else
            hit = 1'b1;
    end
endmodule

// File: sv/coalescing_event_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_event_queue_top
// Coalescing FIFO of events built as a chain of slot cells.
// ----------------------------------------------------------------------------
// The queue is a chain of QUEUE_SLOTS-1 cells; the n occupied cells are
// 0 .. n-1 with the oldest event in cell 0 at the chain output. Pop and the
// no-op command give their result in the cycle after the request is taken.
// Push and remove walk the occupied cells once, one per cycle: the head
// entry is compared, then either dropped (the gap closes by itself) or
// re-entered behind the youngest entry, overwritten when a push hits it.
// After the walk the order is restored and an unmatched push is appended
// if a cell is free; then the result is registered. The result is held
// until it is taken and the next request is accepted in the cycle after
// that handoff, so no new request is taken while one is in progress. No
// memory clear is needed after reset.
// ----------------------------------------------------------------------------
module coalescing_event_queue_top #(
    parameter int QUEUE_SLOTS = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ceq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ceq_pkg::MASK_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ceq_pkg::CMD_W-1:0]       command,
    input  logic [ceq_pkg::SUBJ_W-1:0]      subject,
    input  logic [ceq_pkg::ATYPE_W-1:0]     address_type,
    input  logic [ceq_pkg::ADDR_W-1:0]      device_address,
    input  logic [ceq_pkg::IDX_W-1:0]       item_index,
    input  logic [ceq_pkg::ACT_W-1:0]       action,
    input  logic [PAYLOAD_BITS-1:0]         payload,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ceq_pkg::STAT_W-1:0]      status,
    output logic                            queue_empty,
    output logic [ceq_pkg::SUBJ_W-1:0]      out_subject,
    output logic [ceq_pkg::ATYPE_W-1:0]     out_address_type,
    output logic [ceq_pkg::ADDR_W-1:0]      out_address,
    output logic [ceq_pkg::IDX_W-1:0]       out_index,
    output logic [ceq_pkg::ACT_W-1:0]       out_action,
    output logic [PAYLOAD_BITS-1:0]         out_payload
);
    import ceq_pkg::*;

    localparam int CELLS = QUEUE_SLOTS - 1;
    localparam int CNT_W = $clog2(QUEUE_SLOTS);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

    state_t             state_reg;
    logic [MASK_W-1:0]  amask_reg, imask_reg;
    logic [CNT_W-1:0]   count_reg;                // occupied cells
    logic [CNT_W-1:0]   step_reg;                 // entries left to examine
    logic               done_reg;                 // push already resolved
    logic [CMD_W-1:0]   cmd_reg;
    key_t               skey_reg;
    logic [ACT_W-1:0]   sact_reg;
    logic [PAYLOAD_BITS-1:0] spay_reg;

    key_t               c_key [CELLS];
    logic [ACT_W-1:0]   c_act [CELLS];
    logic [PAYLOAD_BITS-1:0] c_pay [CELLS];
    key_t               n_key [CELLS];
    logic [ACT_W-1:0]   n_act [CELLS];
    logic [PAYLOAD_BITS-1:0] n_pay [CELLS];
    logic               c_wr [CELLS];
    cell_ctl_t          ctl;

    logic               hit;
    logic [CNT_W-1:0]   last_idx;
    key_t               in_key;

    assign in_key = '{subject, address_type, device_address, item_index};
    assign in_ready = (state_reg == S_IDLE);
    assign last_idx = count_reg - 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amask_reg <= '0;
            imask_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ADDR_MASK:  amask_reg <= cfg_data;
                CFG_INDEX_MASK: imask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // compare at the chain head (oldest entry)
    ceq_match u_match (
        .a(c_key[0]), .b(skey_reg),
        .addr_mask(amask_reg), .idx_mask(imask_reg), .hit(hit)
    );

    // step control: one head entry per scan cycle, append at the end; pop drops the head
    always_comb
    begin
        ctl = '0;
        if (state_reg == S_SCAN)
        begin
            if (step_reg != '0)
            begin
                ctl.shift = 1'b1;
                if (hit && !done_reg)
                begin
                    if (cmd_reg == CMD_REMOVE)
                        ctl.drop = 1'b1;
                    else if (sact_reg == ACT_DELETE && c_act[0] == ACT_CREATE)
                        ctl.drop = 1'b1;
                    else
                        ctl.hit_wr = 1'b1;
                end
            end
            else if (cmd_reg == CMD_PUSH && !done_reg && count_reg != CNT_W'(CELLS))
            begin
                ctl.append = 1'b1;
            end
        end
        else if (state_reg == S_IDLE && in_valid && command == CMD_POP &&
                 count_reg != '0)
        begin
            ctl.shift = 1'b1;
            ctl.drop = 1'b1;
        end
    end

    // chain wiring
    always_comb
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            n_key[i] = c_key[i];
            n_act[i] = c_act[i];
            n_pay[i] = c_pay[i];
            c_wr[i]  = 1'b0;
        end
        // every cell takes its younger neighbor
        if (ctl.shift)
        begin
            for (int i = 0; i < CELLS - 1; i++)
            begin
                n_key[i] = c_key[i+1];
                n_act[i] = c_act[i+1];
                n_pay[i] = c_pay[i+1];
                c_wr[i]  = 1'b1;
            end
        end
        // kept head entry re-enters behind the youngest one
        if (ctl.shift && !ctl.drop)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                if (CNT_W'(i) == last_idx)
                begin
                    n_key[i] = ctl.hit_wr ? skey_reg : c_key[0];
                    n_act[i] = ctl.hit_wr ? sact_reg : c_act[0];
                    n_pay[i] = ctl.hit_wr ? spay_reg : c_pay[0];
                    c_wr[i]  = 1'b1;
                end
            end
        end
        // unmatched push lands in the first free cell
        if (ctl.append)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                if (CNT_W'(i) == count_reg)
                begin
                    n_key[i] = skey_reg;
                    n_act[i] = sact_reg;
                    n_pay[i] = spay_reg;
                    c_wr[i]  = 1'b1;
                end
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < CELLS; g++)
        begin : g_cell
            ceq_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
                .clk(clk), .wr(c_wr[g]),
                .in_key(n_key[g]), .in_act(n_act[g]), .in_pay(n_pay[g]),
                .key(c_key[g]), .act(c_act[g]), .pay(c_pay[g])
            );
        end
    endgenerate

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
            cmd_reg   <= CMD_PUSH;
            skey_reg  <= '0;
            sact_reg  <= '0;
            spay_reg  <= '0;
            out_valid <= 1'b0;
            status    <= ST_DONE;
            queue_empty <= 1'b1;
            out_subject <= '0;
            out_address_type <= '0;
            out_address <= '0;
            out_index <= '0;
            out_action <= '0;
            out_payload <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg  <= command;
                        skey_reg <= in_key;
                        sact_reg <= action;
                        spay_reg <= payload;
                        step_reg <= count_reg;
                        done_reg <= 1'b0;
                        out_subject <= '0;
                        out_address_type <= '0;
                        out_address <= '0;
                        out_index <= '0;
                        out_action <= '0;
                        out_payload <= '0;
                        priority if (command == CMD_POP)
                        begin
                            if (count_reg == '0)
                            begin
                                status <= ST_EMPTY;
                                queue_empty <= 1'b1;
                            end
                            else
                            begin
                                status <= ST_DONE;
                                queue_empty <= (count_reg == CNT_W'(1));
                                count_reg <= count_reg - 1'b1;
                                out_subject <= c_key[0].subject;
                                out_address_type <= c_key[0].address_type;
                                out_address <= c_key[0].device_address;
                                out_index <= c_key[0].item_index;
                                out_action <= c_act[0];
                                out_payload <= c_pay[0];
                            end
                            out_valid <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else if (command == CMD_PUSH || command == CMD_REMOVE)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            status <= ST_DONE;
                            queue_empty <= (count_reg == '0);
                            out_valid <= 1'b1;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (step_reg != '0)
                    begin
                        step_reg <= step_reg - 1'b1;
                        if (ctl.drop)
                            count_reg <= count_reg - 1'b1;
                        if (hit && cmd_reg == CMD_PUSH)
                            done_reg <= 1'b1;
                    end
                    else
                    begin
                        if (ctl.append)
                            count_reg <= count_reg + 1'b1;
                        status <= (!done_reg && cmd_reg == CMD_PUSH &&
                                   count_reg == CNT_W'(CELLS)) ? ST_FULL : ST_DONE;
                        queue_empty <= !ctl.append && (count_reg == '0);
                        out_valid <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: sim/tb_coalescing_event_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coalescing_event_queue_top
// Self-checking bench for the coalescing event queue.
// ----------------------------------------------------------------------------
// A short directed sequence exercises the merge rules: overwrite,
// create/delete cancellation, address and index classes, remove and pop on
// empty. Random traffic follows over several class-mask settings. A ring
// model in the scoreboard predicts every result, and each handshake
// response is compared field by field. Both channels idle at random. One
// long receiver stall backs the queue up into its input.
// ----------------------------------------------------------------------------
module tb_coalescing_event_queue_top;
    import ceq_pkg::*;

    localparam int SLOTS = 16;
    localparam int PAY_W = 32;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASE_ITEMS = 170;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SUBJ_W-1:0]  subject;
        logic [ATYPE_W-1:0] atype;
        logic [ADDR_W-1:0]  addr;
        logic [IDX_W-1:0]   idx;
        logic [ACT_W-1:0]   act;
        logic [PAY_W-1:0]   payload;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               empty;
        logic [SUBJ_W-1:0]  subject;
        logic [ATYPE_W-1:0] atype;
        logic [ADDR_W-1:0]  addr;
        logic [IDX_W-1:0]   idx;
        logic [ACT_W-1:0]   act;
        logic [PAY_W-1:0]   payload;
    } response_t;

    // Event queue model plus store of expected responses
    class event_scoreboard;
        request_t  ring [SLOTS];
        int        head;
        int        tail;
        logic [MASK_W-1:0] addr_mask;
        logic [MASK_W-1:0] idx_mask;
        response_t expected_q [$];
        int errors;
        int checked;
        int full_seen;
        int empty_pops;

        function new();
            head = 0;
            tail = 0;
            addr_mask = '0;
            idx_mask = '0;
            errors = 0;
            checked = 0;
            full_seen = 0;
            empty_pops = 0;
        endfunction

        function void set_mask(logic [CFG_IDX_W-1:0] sel, logic [MASK_W-1:0] val);
            if (sel == CFG_ADDR_MASK)
                addr_mask = val;
            else
                idx_mask = val;
        endfunction

        function bit same_event(request_t a, request_t b);
            if (a.subject != b.subject)
                return 0;
            if (addr_mask[a.subject])
                return a.atype == b.atype && a.addr == b.addr;
            if (idx_mask[a.subject])
                return a.idx == b.idx;
            return 1;
        endfunction

        function int nxt(int p);
            return (p + 1) % SLOTS;
        endfunction

        // Close the gap left at pos
        function void drop_slot(int pos);
            int w;
            int r;
            w = pos;
            r = nxt(pos);
            while (r != tail)
            begin
                ring[w] = ring[r];
                w = nxt(w);
                r = nxt(r);
            end
            tail = w;
        endfunction

        function void note_request(request_t rq);
            response_t rs;
            int p;
            int w;
            bit hit;
            rs = '0;
            rs.status = ST_DONE;
            if (rq.cmd == CMD_PUSH)
            begin
                hit = 0;
                p = head;
                while (p != tail && !hit)
                begin
                    if (same_event(ring[p], rq))
                    begin
                        hit = 1;
                        if (rq.act == ACT_DELETE && ring[p].act == ACT_CREATE)
                            drop_slot(p);
                        else
                            ring[p] = rq;
                    end
                    else
                        p = nxt(p);
                end
                if (!hit)
                begin
                    if (nxt(tail) == head)
                    begin
                        rs.status = ST_FULL;
                        full_seen++;
                    end
                    else
                    begin
                        ring[tail] = rq;
                        tail = nxt(tail);
                    end
                end
            end
            else if (rq.cmd == CMD_REMOVE)
            begin
                w = head;
                for (p = head; p != tail; p = nxt(p))
                begin
                    if (!same_event(ring[p], rq))
                    begin
                        ring[w] = ring[p];
                        w = nxt(w);
                    end
                end
                tail = w;
            end
            else if (rq.cmd == CMD_POP)
            begin
                if (head == tail)
                begin
                    rs.status = ST_EMPTY;
                    empty_pops++;
                end
                else
                begin
                    rs.subject = ring[head].subject;
                    rs.atype = ring[head].atype;
                    rs.addr = ring[head].addr;
                    rs.idx = ring[head].idx;
                    rs.act = ring[head].act;
                    rs.payload = ring[head].payload;
                    head = nxt(head);
                end
            end
            rs.empty = (head == tail);
            expected_q.push_back(rs);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch %0s: got %0h want %0h (response %0d)", what, got, want,
                     checked);
        endtask

        task check_response(response_t got);
            response_t want;
            if (expected_q.size() == 0)
            begin
                report("unexpected response", 64'(got.status), '0);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report("status", 64'(got.status), 64'(want.status));
            if (got.empty !== want.empty)
                report("queue_empty", 64'(got.empty), 64'(want.empty));
            if (got.subject !== want.subject)
                report("subject", 64'(got.subject), 64'(want.subject));
            if (got.atype !== want.atype)
                report("address_type", 64'(got.atype), 64'(want.atype));
            if (got.addr !== want.addr)
                report("address", 64'(got.addr), 64'(want.addr));
            if (got.idx !== want.idx)
                report("index", 64'(got.idx), 64'(want.idx));
            if (got.act !== want.act)
                report("action", 64'(got.act), 64'(want.act));
            if (got.payload !== want.payload)
                report("payload", 64'(got.payload), 64'(want.payload));
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MASK_W-1:0] cfg_data;

    ceq_if #(.T(request_t)) in_ch ();
    ceq_if #(.T(response_t)) out_ch ();

    logic [STAT_W-1:0]  r_status;
    logic               r_empty;
    logic [SUBJ_W-1:0]  r_subject;
    logic [ATYPE_W-1:0] r_atype;
    logic [ADDR_W-1:0]  r_addr;
    logic [IDX_W-1:0]   r_idx;
    logic [ACT_W-1:0]   r_act;
    logic [PAY_W-1:0]   r_payload;

    assign out_ch.data = {r_status, r_empty, r_subject, r_atype, r_addr, r_idx, r_act,
                          r_payload};

    coalescing_event_queue_top #(
        .QUEUE_SLOTS(SLOTS),
        .PAYLOAD_BITS(PAY_W)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_ch.valid),
        .in_ready(in_ch.ready),
        .command(in_ch.data.cmd),
        .subject(in_ch.data.subject),
        .address_type(in_ch.data.atype),
        .device_address(in_ch.data.addr),
        .item_index(in_ch.data.idx),
        .action(in_ch.data.act),
        .payload(in_ch.data.payload),
        .out_valid(out_ch.valid),
        .out_ready(out_ch.ready),
        .status(r_status),
        .queue_empty(r_empty),
        .out_subject(r_subject),
        .out_address_type(r_atype),
        .out_address(r_addr),
        .out_index(r_idx),
        .out_action(r_act),
        .out_payload(r_payload)
    );

    event_scoreboard sb = new();
    bit no_idle;
    bit hold_request;
    int sent;
    logic [ADDR_W-1:0] addr_pool [4];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, a few long ones, none at all in eager stretches
    function int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 6);
    endfunction

    function request_t mk(logic [CMD_W-1:0] c, int s, int at, logic [ADDR_W-1:0] a,
                          int ix, logic [ACT_W-1:0] ac, logic [PAY_W-1:0] p);
        request_t rq;
        rq.cmd = c;
        rq.subject = SUBJ_W'(s);
        rq.atype = ATYPE_W'(at);
        rq.addr = a;
        rq.idx = IDX_W'(ix);
        rq.act = ac;
        rq.payload = p;
        return rq;
    endfunction

    // Random request from small key pools so merges happen often
    function request_t rand_request(int push_pct);
        request_t rq;
        int r;
        r = $urandom_range(99);
        if (r < push_pct)
            rq.cmd = CMD_PUSH;
        else if (r < push_pct + 8)
            rq.cmd = CMD_REMOVE;
        else if (r < 97)
            rq.cmd = CMD_POP;
        else
            rq.cmd = CMD_NOP;
        rq.subject = SUBJ_W'(($urandom_range(3) == 0) ? $urandom_range(15)
                                                       : $urandom_range(5));
        rq.atype = ATYPE_W'(($urandom_range(3) == 0) ? $urandom_range(3) : 0);
        if ($urandom_range(4) == 0)
            rq.addr = ADDR_W'({$urandom(), $urandom()});
        else
            rq.addr = addr_pool[$urandom_range(3)];
        rq.idx = IDX_W'(($urandom_range(4) == 0) ? $urandom_range(255)
                                                  : $urandom_range(3));
        rq.act = ACT_W'($urandom_range(3));
        rq.payload = $urandom();
        return rq;
    endfunction

    // Offer one request, hold until taken, then idle for a random gap, possibly none
    task send_request(request_t rq);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.data <= rq;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_request(rq);
        sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task drain();
        if (in_ch.valid)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] sel, logic [MASK_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= val;
        @(posedge clk);
        sb.set_mask(sel, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task run_phase(logic [MASK_W-1:0] am, logic [MASK_W-1:0] im, int push_pct,
                   bit stall);
        drain();
        write_reg(CFG_ADDR_MASK, am);
        write_reg(CFG_INDEX_MASK, im);
        if (stall)
            hold_request = 1;
        repeat (PHASE_ITEMS) send_request(rand_request(push_pct));
    endtask

    // Receiver: random ready, plus one long hold on request
    initial
    begin
        int hold;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                out_ch.ready <= 1'b0;
                for (hold = 0; hold < 300; hold++)
                    @(posedge clk);
                hold_request = 0;
            end
            out_ch.ready <= (pick_gap() == 0);
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_response(out_ch.data);
        end
    end

    // Watchdog on cycles with no handshake on either side
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || !rst_n)
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        no_idle = 0;
        hold_request = 0;
        sent = 0;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        addr_pool[2] = 48'hA5A5_5A5A_0F0F;
        addr_pool[3] = ADDR_W'({$urandom(), $urandom()});
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Subjects 0-3 both classes, 4-7 address, 8-11 index, 12-15 neither
        write_reg(CFG_ADDR_MASK, 16'h00FF);
        write_reg(CFG_INDEX_MASK, 16'h0F0F);
        send_request(mk(CMD_POP, 0, 0, '0, 0, ACT_CREATE, '0));
        send_request(mk(CMD_PUSH, 4, 1, addr_pool[2], 0, ACT_CREATE, 32'h11));
        send_request(mk(CMD_PUSH, 4, 1, addr_pool[2], 9, ACT_DELETE, 32'h12));
        send_request(mk(CMD_POP, 0, 0, '0, 0, ACT_CREATE, '0));
        send_request(mk(CMD_PUSH, 4, 1, addr_pool[2], 0, ACT_CREATE, 32'h21));
        send_request(mk(CMD_PUSH, 4, 2, addr_pool[2], 0, ACT_UPDATE, 32'h22));
        send_request(mk(CMD_PUSH, 4, 1, addr_pool[2], 0, ACT_DELETE, 32'h23));
        send_request(mk(CMD_PUSH, 8, 0, 48'h1, 5, ACT_CREATE, 32'h31));
        send_request(mk(CMD_PUSH, 8, 3, 48'h2, 5, ACT_UPDATE, 32'h32));
        // delete over an update overwrites
        send_request(mk(CMD_PUSH, 8, 0, 48'h3, 5, ACT_DELETE, 32'h33));
        send_request(mk(CMD_PUSH, 0, 0, addr_pool[1], 1, ACT_UPDATE, 32'h41));
        send_request(mk(CMD_PUSH, 0, 0, addr_pool[1], 2, ACT_OTHER, 32'h42));
        send_request(mk(CMD_PUSH, 12, 2, 48'h5, 7, ACT_UPDATE, 32'h51));
        send_request(mk(CMD_PUSH, 12, 1, 48'h6, 8, ACT_OTHER, 32'h52));
        send_request(mk(CMD_PUSH, 15, 3, '1, 255, ACT_OTHER, '1));
        send_request(mk(CMD_REMOVE, 8, 0, '0, 5, ACT_CREATE, '0));
        send_request(mk(CMD_NOP, 15, 3, '1, 255, ACT_OTHER, '1));
        for (i = 0; i < 5; i++)
            send_request(mk(CMD_POP, 0, 0, '0, 0, ACT_CREATE, '0));
        send_request(mk(CMD_REMOVE, 15, 3, '1, 255, ACT_CREATE, '0));

        run_phase(16'hFFFF, 16'h0000, 60, 0);
        run_phase(16'h0000, 16'hFFFF, 75, 1);
        no_idle = 1;
        run_phase(16'h0000, 16'h0000, 55, 0);
        no_idle = 0;
        run_phase(MASK_W'($urandom_range(16'hFFFF)), MASK_W'($urandom_range(16'hFFFF)),
                  70, 0);
        run_phase(16'hFFFF, 16'hFFFF, 50, 0);
        run_phase(16'h00FF, 16'hFF00, 65, 0);
        drain();

        $display("%0d requests, %0d responses checked; %0d full pushes, %0d empty pops",
                 sent, sb.checked, sb.full_seen, sb.empty_pops);
        $display("six class-mask settings, one long receiver stall");
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
sv/ceq_pkg.sv
sv/ceq_if.sv
sv/ceq_cell.sv
sv/ceq_match.sv
sv/coalescing_event_queue_top.sv
sim/tb_coalescing_event_queue_top.sv
